// File: rtl/hex_address_range_parser_assert.svh
// Assertion macros used by the checker file of the hex address range parser.
`ifndef HEX_ADDRESS_RANGE_PARSER_ASSERT_SVH
`define HEX_ADDRESS_RANGE_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define HARP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HARP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/harp_pkg.sv
// Package of the hex address range parser: types, character codes, digit decoder.
package harp_pkg;

   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 64;
   localparam int COUNT_W = 5;
   localparam int POS_W   = 2;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [POS_W-1:0]   pos_type;

   // character codes
   localparam char_type CHAR_NUL  = 8'h00;
   localparam char_type CHAR_TICK = 8'h60;
   localparam char_type CHAR_X    = 8'h78;
   localparam char_type CHAR_DASH = 8'h2D;
   localparam char_type CHAR_0    = 8'h30;
   localparam char_type CHAR_9    = 8'h39;
   localparam char_type CHAR_LA   = 8'h61;
   localparam char_type CHAR_LF   = 8'h66;
   localparam char_type CHAR_UA   = 8'h41;
   localparam char_type CHAR_UF   = 8'h46;
   localparam char_type HEX_TEN   = 8'd10;

   // field limits
   localparam count_type MAX_DIGITS = 5'd16;
   localparam pos_type   POS_FIRST  = 2'd0;
   localparam pos_type   POS_SECOND = 2'd1;
   localparam pos_type   POS_MAX    = 2'd2;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } digit_type;

   // word held in the input register
   typedef struct packed {
      logic     valid;
      char_type character;
   } step_type;

   // finished result handed to the output register
   typedef struct packed {
      logic      emit;
      value_type low_value;
      value_type high_value;
   } result_type;

   function automatic digit_type hex_decode(input char_type c);
      digit_type d;
      char_type  t;
      d = '0;
      t = '0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         t = c - CHAR_0;
         d.ok = 1'b1;
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
         t = c - CHAR_LA + HEX_TEN;
         d.ok = 1'b1;
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         t = c - CHAR_UA + HEX_TEN;
         d.ok = 1'b1;
      end
      d.val = t[3:0];
      return d;
   endfunction

endpackage

// File: rtl/harp_if.sv
// Valid/ready channel interfaces for characters in and parsed values out.
interface harp_req_if import harp_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type character;

   modport source (output valid, output character, input ready);
   modport sink (input valid, input character, output ready);
endinterface

interface harp_rsp_if import harp_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type low_value;
   value_type high_value;

   modport source (output valid, output low_value, output high_value, input ready);
   modport sink (input valid, input low_value, input high_value, output ready);
endinterface

// File: rtl/harp_in_stage.sv
// Input register: holds one character word until the parser consumes it.
module harp_in_stage import harp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   harp_req_if.sink   req_chan,
   input  logic       consume,
   output step_type   step
);

   logic     valid_ff, valid_in;
   char_type char_ff, char_in;
   logic     take;

   // accept whenever the register is empty or being drained this cycle
   assign req_chan.ready = !valid_ff || consume;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      if (take) begin
         valid_in = 1'b1;
         char_in  = req_chan.character;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   assign step.valid     = valid_ff;
   assign step.character = char_ff;

endmodule

// File: rtl/harp_field.sv
// Parser state: per-character field update and range result at the terminator.
module harp_field import harp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  step_type   step,
   input  logic       range_mode,
   input  logic       out_free,
   output logic       consume,
   output result_type result
);

   value_type acc_ff, acc_in;
   count_type cnt_ff, cnt_in;
   pos_type   pos_ff, pos_in;
   logic      zero_ff, zero_in;
   logic      inval_ff, inval_in;
   logic      stop_ff, stop_in;
   logic      second_ff, second_in;
   value_type first_ff, first_in;

   char_type  c;
   digit_type dig;
   value_type shifted;
   count_type cnt_inc;
   value_type field_val;
   logic      is_nul;

   assign c       = step.character;
   assign is_nul  = (c == CHAR_NUL);
   assign dig     = hex_decode(c);
   assign shifted = {acc_ff[VALUE_W-5:0], dig.val};
   assign cnt_inc = cnt_ff + 1'b1;

   // a terminator waits for room in the output register
   assign consume = step.valid && (!is_nul || out_free);

   // value of the current field, zero when invalid or overlong
   assign field_val = (inval_ff || stop_ff || cnt_ff > MAX_DIGITS) ? '0 : acc_ff;

   // next state
   always_comb begin
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      zero_in   = zero_ff;
      inval_in  = inval_ff;
      stop_in   = stop_ff;
      second_in = second_ff;
      first_in  = first_ff;
      if (consume) begin
         if (is_nul || (range_mode && c == CHAR_DASH && !second_ff)) begin
            acc_in   = '0;
            cnt_in   = '0;
            pos_in   = POS_FIRST;
            zero_in  = 1'b0;
            inval_in = 1'b0;
            stop_in  = 1'b0;
            if (is_nul) begin
               second_in = 1'b0;
               first_in  = '0;
            end else begin
               second_in = 1'b1;
               first_in  = field_val;
            end
         end else begin
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + 1'b1;
            end
            if (!(inval_ff || stop_ff)) begin
               if (pos_ff == POS_FIRST) begin
                  zero_in = (c == CHAR_0);
               end
               if (pos_ff == POS_SECOND && c == CHAR_X && zero_ff) begin
                  // leading 0x prefix
                  acc_in = '0;
                  cnt_in = '0;
               end else if (c == CHAR_TICK) begin
                  // separator, skipped
               end else if (!dig.ok) begin
                  inval_in = 1'b1;
               end else begin
                  acc_in = shifted;
                  if (shifted != '0) begin
                     cnt_in = cnt_inc;
                     if (cnt_inc > MAX_DIGITS) begin
                        stop_in = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   // result at the terminator
   always_comb begin
      result.emit       = consume && is_nul;
      result.low_value  = '0;
      result.high_value = '0;
      if (!range_mode) begin
         result.low_value = field_val;
      end else if (second_ff) begin
         if (first_ff > field_val) begin
            result.low_value  = field_val;
            result.high_value = first_ff;
         end else begin
            result.low_value  = first_ff;
            result.high_value = field_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         cnt_ff    <= '0;
         pos_ff    <= POS_FIRST;
         zero_ff   <= 1'b0;
         inval_ff  <= 1'b0;
         stop_ff   <= 1'b0;
         second_ff <= 1'b0;
         first_ff  <= '0;
      end else begin
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         pos_ff    <= pos_in;
         zero_ff   <= zero_in;
         inval_ff  <= inval_in;
         stop_ff   <= stop_in;
         second_ff <= second_in;
         first_ff  <= first_in;
      end
   end

endmodule

// File: rtl/harp_out_stage.sv
// Output register: holds one result word until the receiver takes it.
module harp_out_stage import harp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   output logic       out_free,
   harp_rsp_if.source rsp_chan
);

   logic      valid_ff, valid_in;
   value_type low_ff, low_in;
   value_type high_ff, high_in;

   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      if (result.emit) begin
         valid_in = 1'b1;
         low_in   = result.low_value;
         high_in  = result.high_value;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff  <= low_in;
      high_ff <= high_in;
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.low_value  = low_ff;
   assign rsp_chan.high_value = high_ff;

endmodule

// File: rtl/hex_address_range_parser.sv
// Top level of the hex value / address range parser.
// Usage:
//   req_chan carries one ASCII character per word. A zero character ends the
//   string; only then is one word sent on rsp_chan (low_value, high_value).
//   Other characters produce no output word.
//   csr_wr_en / csr_wr_data write range_mode (0: one hex value, 1: low-high
//   range); write it only while no string is in flight.
// Timing:
//   One character is accepted every cycle while no terminator waits in the
//   input register. A character is registered in the input register, then the
//   field state updates and, for a terminator, the result is loaded into the
//   output register, which drives rsp_chan.valid and holds the word until the
//   receiver takes it.
// Reset:
//   Synchronous reset clears range_mode, all field state and the valid bits of both registers.
// Stall:
//   While rsp_chan.ready is low, the output word holds and ordinary
//   characters keep flowing; a second terminator waits in the input register,
//   and only then does req_chan.ready drop.
module hex_address_range_parser import harp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   harp_req_if.sink   req_chan,
   harp_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic       mode_ff, mode_in;
   step_type   step;
   logic       consume;
   logic       out_free;
   result_type result;

   // configuration register
   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   harp_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .consume  (consume),
      .step     (step)
   );

   harp_field u_field (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .range_mode (mode_ff),
      .out_free   (out_free),
      .consume    (consume),
      .result     (result)
   );

   harp_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: rtl/harp_checker.sv
// Port-level checker for the hex address range parser, bound to the top level.
`include "hex_address_range_parser_assert.svh"

module harp_checker import harp_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input value_type rsp_low_value,
   input value_type rsp_high_value
);

   // a stalled result word holds its value
   `HARP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_low_value) && $stable(rsp_high_value), "result word changed while stalled")

   // bounds come out ordered, or the upper one is zero in single mode
   `HARP_ASSERT_IMP(a_rsp_order, clock, reset, rsp_valid, (rsp_low_value <= rsp_high_value) || (rsp_high_value == '0), "range bounds out of order")

   // input back-pressure only comes from a stalled output
   `HARP_ASSERT_IMP(a_req_stall, clock, reset, !req_ready, rsp_valid && !rsp_ready, "input stalled without output stall")

   // no result word right after reset
   `HARP_ASSERT_IMP(a_rsp_reset, clock, reset, $past(reset), !rsp_valid && (req_ready || !req_valid), "result word present after reset")

endmodule

bind hex_address_range_parser harp_checker u_harp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_low_value  (rsp_chan.low_value),
   .rsp_high_value (rsp_chan.high_value)
);
